[rtl/core/gwmm_pkg.sv]
`timescale 1ns / 1ps
// gwmm_pkg: shared types and constants of the grid window min/max block
// used by every module under rtl/core except gwmm_ram, depends on nothing

package gwmm_pkg;

  // default sizes of the sample store
  localparam int MaxColsDef    = 256;
  localparam int MaxRowsDef    = 256;
  localparam int SampleBitsDef = 16;

  // fixed field widths
  localparam int IdxW  = 8;               // column and row indices
  localparam int DimW  = 9;               // grid size registers
  localparam int ElevW = 16;              // elevation ports
  localparam int LinW  = IdxW + DimW + 1; // row base plus column offset

  // configuration port
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 1'b1;
  localparam logic [DimW-1:0]    DimReset      = 9'd256;

  // transaction functions
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // results of an empty window
  localparam logic signed [ElevW-1:0] EmptyMin = 16'sh7fff;
  localparam logic signed [ElevW-1:0] EmptyMax = 16'sh8000;

  // control from the sequencer to the min/max unit
  typedef struct packed {
    logic init;    // load the start values before a scan
    logic sample;  // memory read data is valid this cycle
    logic finish;  // last sample, publish the result
    logic empty;   // publish the empty window result
  } acc_ctrl_t;

endpackage

[rtl/core/gwmm_ram.sv]
`timescale 1ns / 1ps
// gwmm_ram: generic simple dual-port RAM, one write and one registered read port
// standalone, no package needed

module gwmm_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gwmm_minmax.sv]
`timescale 1ns / 1ps
// gwmm_minmax: shared compare unit folding samples into a running min and max
// depends on gwmm_pkg

module gwmm_minmax #(
  parameter int SAMPLE_BITS = gwmm_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gwmm_pkg::acc_ctrl_t                 acc_i,
  input  logic signed [SAMPLE_BITS-1:0]       rdata_i,
  output logic signed [gwmm_pkg::ElevW-1:0]   min_elevation_o,
  output logic signed [gwmm_pkg::ElevW-1:0]   max_elevation_o,
  output logic                                empty_window_o,
  output logic                                done_o
);

  import gwmm_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] AccHi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] AccLo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic signed [ElevW-1:0]       min_out_q, max_out_q;
  logic                          empty_q;
  logic                          done_q;

  // load the start values or fold the current sample
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (acc_i.init) begin
      min_d = AccHi;
      max_d = AccLo;
    end else if (acc_i.sample) begin
      if (rdata_i < min_q) min_d = rdata_i;
      if (rdata_i > max_q) max_d = rdata_i;
    end
  end

  // running extremes
  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

  // result registers, payload
  always_ff @(posedge clk_i) begin
    if (acc_i.empty) begin
      min_out_q <= EmptyMin;
      max_out_q <= EmptyMax;
      empty_q   <= 1'b1;
    end else if (acc_i.finish) begin
      min_out_q <= ElevW'(min_d);
      max_out_q <= ElevW'(max_d);
      empty_q   <= 1'b0;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= acc_i.empty | acc_i.finish;
    end
  end

  assign min_elevation_o = min_out_q;
  assign max_elevation_o = max_out_q;
  assign empty_window_o  = empty_q;
  assign done_o          = done_q;

endmodule

[rtl/core/gwmm_seq.sv]
`timescale 1ns / 1ps
// gwmm_seq: sequencer for clearing, sample writes and window scans
// depends on gwmm_pkg, drives gwmm_ram and gwmm_minmax

module gwmm_seq #(
  parameter int MAX_COLS    = gwmm_pkg::MaxColsDef,
  parameter int MAX_ROWS    = gwmm_pkg::MaxRowsDef,
  parameter int SAMPLE_BITS = gwmm_pkg::SampleBitsDef,
  localparam int Depth      = MAX_COLS * MAX_ROWS,
  localparam int AddrW      = $clog2(Depth)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func_i,
  input  logic [gwmm_pkg::IdxW-1:0]          col_lo_i,
  input  logic [gwmm_pkg::IdxW-1:0]          col_hi_i,
  input  logic [gwmm_pkg::IdxW-1:0]          row_lo_i,
  input  logic [gwmm_pkg::IdxW-1:0]          row_hi_i,
  input  logic signed [gwmm_pkg::ElevW-1:0]  sample_value_i,
  input  logic [gwmm_pkg::DimW-1:0]          grid_width_i,
  input  logic [gwmm_pkg::DimW-1:0]          grid_height_i,
  output logic                               ram_we_o,
  output logic [AddrW-1:0]                   ram_waddr_o,
  output logic [SAMPLE_BITS-1:0]             ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AddrW-1:0]                   ram_raddr_o,
  output gwmm_pkg::acc_ctrl_t                acc_o
);

  import gwmm_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StSetup = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StDrain = 3'd5;

  localparam logic signed [SAMPLE_BITS-1:0] SatHi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SatLo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [AddrW-1:0]              LastAddr = AddrW'(Depth - 1);

  logic [2:0]             state_q, state_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic                   func_q, func_d;
  logic [IdxW-1:0]        c0_q, c0_d, c1_q, c1_d, r1_q, r1_d;
  logic [IdxW-1:0]        c_q, c_d, r_q, r_d;
  logic [LinW-1:0]        base_q, base_d;
  logic signed [SAMPLE_BITS-1:0] wval_q, wval_d;
  logic                   rd_pend_q;

  logic [DimW-1:0]        w_eff, h_eff;
  logic                   is_empty;
  logic [LinW-1:0]        lin_addr;
  logic signed [32:0]     sv_ext;

  // grid sizes clamped into the supported range
  always_comb begin
    if (grid_width_i < DimW'(2)) w_eff = DimW'(2);
    else if (32'(grid_width_i) > 32'(MAX_COLS)) w_eff = DimW'(MAX_COLS);
    else w_eff = grid_width_i;
    if (grid_height_i < DimW'(2)) h_eff = DimW'(2);
    else if (32'(grid_height_i) > 32'(MAX_ROWS)) h_eff = DimW'(MAX_ROWS);
    else h_eff = grid_height_i;
  end

  assign is_empty = (col_lo_i > col_hi_i) || (row_lo_i > row_hi_i);
  assign sv_ext   = 33'(sample_value_i);
  assign lin_addr = LinW'(base_q + LinW'(c_q));

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    func_d  = func_q;
    c0_d    = c0_q;
    c1_d    = c1_q;
    r1_d    = r1_q;
    c_d     = c_q;
    r_d     = r_q;
    base_d  = base_q;
    wval_d  = wval_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AddrW'(lin_addr);
    ram_wdata_o = wval_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = AddrW'(lin_addr);
    acc_o       = '0;
    case (state_q)
      StClear: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = AddrW'(clr_q + 1'b1);
        if (clr_q == LastAddr) state_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          if (func_i == FuncQuery && is_empty) begin
            acc_o.empty = 1'b1;
          end else begin
            func_d = func_i;
            c0_d = ({1'b0, col_lo_i} >= w_eff) ? IdxW'(w_eff - 1'b1) : col_lo_i;
            c1_d = ({1'b0, col_hi_i} >= w_eff) ? IdxW'(w_eff - 1'b1) : col_hi_i;
            r_d  = ({1'b0, row_lo_i} >= h_eff) ? IdxW'(h_eff - 1'b1) : row_lo_i;
            r1_d = ({1'b0, row_hi_i} >= h_eff) ? IdxW'(h_eff - 1'b1) : row_hi_i;
            if (sv_ext > 33'(SatHi)) wval_d = SatHi;
            else if (sv_ext < 33'(SatLo)) wval_d = SatLo;
            else wval_d = SAMPLE_BITS'(sv_ext);
            acc_o.init = 1'b1;
            state_d = StSetup;
          end
        end
      end
      StSetup: begin
        // row base of the first row through the multiplier
        base_d  = LinW'(LinW'(r_q) * LinW'(w_eff));
        c_d     = c0_q;
        state_d = (func_q == FuncWrite) ? StWrite : StScan;
      end
      StWrite: begin
        ram_we_o = 1'b1;
        state_d  = StIdle;
      end
      StScan: begin
        ram_re_o     = 1'b1;
        acc_o.sample = rd_pend_q;
        if (c_q == c1_q) begin
          if (r_q == r1_q) begin
            state_d = StDrain;
          end else begin
            r_d    = IdxW'(r_q + 1'b1);
            c_d    = c0_q;
            base_d = LinW'(base_q + LinW'(w_eff));
          end
        end else begin
          c_d = IdxW'(c_q + 1'b1);
        end
      end
      StDrain: begin
        acc_o.sample = rd_pend_q;
        acc_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_pend_q <= (state_q == StScan);
    end
  end

  // transaction payload and scan position
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    r1_q   <= r1_d;
    c_q    <= c_d;
    r_q    <= r_d;
    base_q <= base_d;
    wval_q <= wval_d;
  end

  assign busy = (state_q != StIdle);

endmodule

[rtl/core/grid_window_min_max.sv]
`timescale 1ns / 1ps
// grid_window_min_max: top level with the grid size registers
// depends on gwmm_pkg, gwmm_ram, gwmm_minmax and gwmm_seq
//
// Keeps a row-major store of signed elevation samples and answers rectangle
// min/max queries. A transaction is taken when start is high and busy is low.
// func_i = write stores sample_value_i at (col_lo_i, row_lo_i); func_i = query
// scans columns col_lo_i..col_hi_i and rows row_lo_i..row_hi_i inclusive.
// Indices are clamped to the configured grid; samples are saturated to
// SAMPLE_BITS before they are stored.
// Each query gives one result on min_elevation_o, max_elevation_o and
// empty_window_o, valid for the single cycle in which done_o is high; a write
// gives none. The receiver cannot stall the block.
// Sequencing: a write keeps busy high through the setup and write states after
// acceptance. A query over N = cols * rows samples keeps busy high through the
// setup, scan and drain states, and raises done_o in the same cycle in which busy
// falls; one sample is read per cycle through the single memory read port.
// An empty window gives done_o in the cycle after acceptance and never raises
// busy.
// Reset: grid_width and grid_height return to 256, and the store is cleared to
// zero by a pass over the MAX_COLS * MAX_ROWS addresses (65536 by default)
// with busy high. Configuration writes through cfg_we_i are taken at any time.

module grid_window_min_max #(
  parameter int MAX_COLS    = gwmm_pkg::MaxColsDef,
  parameter int MAX_ROWS    = gwmm_pkg::MaxRowsDef,
  parameter int SAMPLE_BITS = gwmm_pkg::SampleBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gwmm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gwmm_pkg::DimW-1:0]          cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func_i,
  input  logic [gwmm_pkg::IdxW-1:0]          col_lo_i,
  input  logic [gwmm_pkg::IdxW-1:0]          col_hi_i,
  input  logic [gwmm_pkg::IdxW-1:0]          row_lo_i,
  input  logic [gwmm_pkg::IdxW-1:0]          row_hi_i,
  input  logic signed [gwmm_pkg::ElevW-1:0]  sample_value_i,
  output logic                               done_o,
  output logic signed [gwmm_pkg::ElevW-1:0]  min_elevation_o,
  output logic signed [gwmm_pkg::ElevW-1:0]  max_elevation_o,
  output logic                               empty_window_o
);

  import gwmm_pkg::*;

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = $clog2(Depth);

  logic [DimW-1:0]        grid_width_q, grid_height_q;
  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  acc_ctrl_t              acc;

  // grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DimReset;
      grid_height_q <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridWidth:  grid_width_q  <= cfg_wdata_i;
        CfgGridHeight: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // address sequencer
  gwmm_seq #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .col_lo_i       (col_lo_i),
    .col_hi_i       (col_hi_i),
    .row_lo_i       (row_lo_i),
    .row_hi_i       (row_hi_i),
    .sample_value_i (sample_value_i),
    .grid_width_i   (grid_width_q),
    .grid_height_i  (grid_height_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .acc_o          (acc)
  );

  // elevation store
  gwmm_ram #(
    .Width (SAMPLE_BITS),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // min/max compare unit
  gwmm_minmax #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_minmax (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .rdata_i         (ram_rdata),
    .min_elevation_o (min_elevation_o),
    .max_elevation_o (max_elevation_o),
    .empty_window_o  (empty_window_o),
    .done_o          (done_o)
  );

endmodule

[sim/grid_window_min_max_tb.sv]
`timescale 1ns / 1ps
// grid_window_min_max_tb: self-checking bench for the grid window min/max block
// depends on gwmm_pkg and grid_window_min_max, keeps its own mirror of the store

module grid_window_min_max_tb;
  import gwmm_pkg::*;

  localparam int StoreDepth   = MaxColsDef * MaxRowsDef;
  localparam int StoreAddrW   = $clog2(StoreDepth);
  localparam int NumPhases    = 10;
  localparam int PhaseItems   = 110;
  localparam int CycleLimit   = 6_000_000;
  localparam int NumDirRows   = 27;

  // one input transaction
  typedef struct packed {
    logic                    func;
    logic [IdxW-1:0]         col_lo;
    logic [IdxW-1:0]         col_hi;
    logic [IdxW-1:0]         row_lo;
    logic [IdxW-1:0]         row_hi;
    logic signed [ElevW-1:0] sample;
  } txn_t;

  // one query result
  typedef struct packed {
    logic signed [ElevW-1:0] min_e;
    logic signed [ElevW-1:0] max_e;
    logic                    empty;
  } window_result_t;

  // directed rows: a transaction checked by the mirror, one with a typed-in
  // result, or a register write
  typedef enum logic [1:0] {RowTxn, RowTxnFixed, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic                    func;
    logic [IdxW-1:0]         col_lo;
    logic [IdxW-1:0]         col_hi;
    logic [IdxW-1:0]         row_lo;
    logic [IdxW-1:0]         row_hi;
    logic signed [ElevW-1:0] sample;
    logic signed [ElevW-1:0] fx_min;
    logic signed [ElevW-1:0] fx_max;
    logic                    fx_empty;
    logic [CfgIdxW-1:0]      cfg_sel;
    logic [DimW-1:0]         cfg_val;
  } stim_row_t;

  // kind, func, col_lo, col_hi, row_lo, row_hi, sample, min, max, empty, reg, value
  stim_row_t dir_rows [NumDirRows] = '{
    // cleared store, then empty windows on each axis
    '{RowTxnFixed, FuncQuery, 8'd0, 8'd255, 8'd0, 8'd255, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd5, 8'd4, 8'd0, 8'd0, 16'sh0, EmptyMin, EmptyMax, 1'b1,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd0, 8'd0, 8'd9, 8'd3, 16'sh0, EmptyMin, EmptyMax, 1'b1,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd255, 8'd0, 8'd255, 8'd0, 16'sh0, EmptyMin, EmptyMax, 1'b1,
      CfgGridWidth, 9'd0},
    // extreme samples in the corners
    '{RowTxn, FuncWrite, 8'd0, 8'h5a, 8'd0, 8'ha5, 16'sh7fff, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncWrite, 8'd255, 8'h00, 8'd255, 8'hff, 16'sh8000, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncWrite, 8'd255, 8'hff, 8'd0, 8'h00, 16'shffff, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncWrite, 8'd0, 8'h33, 8'd255, 8'hcc, 16'sh0001, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd0, 8'd0, 8'd0, 8'd0, 16'sh0, 16'sh7fff, 16'sh7fff, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd255, 8'd255, 8'd255, 8'd255, 16'sh0, 16'sh8000, 16'sh8000,
      1'b0, CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd0, 8'd255, 8'd0, 8'd0, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd255, 8'd255, 8'd0, 8'd255, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    // small window around two neighbors
    '{RowTxn, FuncWrite, 8'd10, 8'd0, 8'd20, 8'd0, 16'sh1234, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncWrite, 8'd11, 8'd0, 8'd20, 8'd0, 16'shfffb, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd10, 8'd11, 8'd20, 8'd20, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd9, 8'd12, 8'd19, 8'd21, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxnFixed, FuncQuery, 8'd0, 8'd255, 8'd0, 8'd255, 16'sh0, 16'sh8000, 16'sh7fff, 1'b0,
      CfgGridWidth, 9'd0},
    // registers below range shrink the grid to 2 by 2, store is reinterpreted
    '{RowCfg, FuncQuery, 8'd0, 8'd0, 8'd0, 8'd0, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowCfg, FuncQuery, 8'd0, 8'd0, 8'd0, 8'd0, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridHeight, 9'd1},
    '{RowTxn, FuncQuery, 8'd0, 8'd255, 8'd0, 8'd255, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    // indices beyond the grid clamp to the last column and row
    '{RowTxn, FuncWrite, 8'd200, 8'd0, 8'd200, 8'd0, 16'shfff9, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd1, 8'd1, 8'd1, 8'd1, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd255, 8'd255, 8'd255, 8'd255, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    // registers above range saturate back to the full grid
    '{RowCfg, FuncQuery, 8'd0, 8'd0, 8'd0, 8'd0, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd511},
    '{RowCfg, FuncQuery, 8'd0, 8'd0, 8'd0, 8'd0, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridHeight, 9'd300},
    '{RowTxn, FuncQuery, 8'd0, 8'd3, 8'd0, 8'd1, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0},
    '{RowTxn, FuncQuery, 8'd0, 8'd5, 8'd1, 8'd1, 16'sh0, 16'sh0, 16'sh0, 1'b0,
      CfgGridWidth, 9'd0}
  };

  // dut ports
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i      = '0;
  logic [DimW-1:0]         cfg_wdata_i    = '0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic                    func_i         = 1'b0;
  logic [IdxW-1:0]         col_lo_i       = '0;
  logic [IdxW-1:0]         col_hi_i       = '0;
  logic [IdxW-1:0]         row_lo_i       = '0;
  logic [IdxW-1:0]         row_hi_i       = '0;
  logic signed [ElevW-1:0] sample_value_i = '0;
  logic                    done_o;
  logic signed [ElevW-1:0] min_elevation_o;
  logic signed [ElevW-1:0] max_elevation_o;
  logic                    empty_window_o;

  // mirror of the block state
  logic signed [ElevW-1:0] elev_mirror [StoreDepth];
  logic [DimW-1:0]         width_reg  = DimReset;
  logic [DimW-1:0]         height_reg = DimReset;

  window_result_t pending_windows [$];
  bit             quiet_stretch = 1'b0;
  int unsigned    n_mismatch    = 0;
  int unsigned    n_checked     = 0;
  int unsigned    n_writes      = 0;
  int unsigned    n_queries     = 0;
  int unsigned    n_empty       = 0;
  int unsigned    n_settings    = 0;
  int unsigned    cycle_count   = 0;

  grid_window_min_max u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .col_lo_i        (col_lo_i),
    .col_hi_i        (col_hi_i),
    .row_lo_i        (row_lo_i),
    .row_hi_i        (row_hi_i),
    .sample_value_i  (sample_value_i),
    .done_o          (done_o),
    .min_elevation_o (min_elevation_o),
    .max_elevation_o (max_elevation_o),
    .empty_window_o  (empty_window_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // grid size registers saturate into their usable range
  function automatic int unsigned grid_dim(input logic [DimW-1:0] value, input int unsigned top);
    if (value < 2) return 2;
    if (value > top) return top;
    return 32'(value);
  endfunction

  function automatic int unsigned clamp_index(input logic [IdxW-1:0] value,
                                              input int unsigned dim);
    return (value >= dim) ? dim - 1 : 32'(value);
  endfunction

  // least and greatest sample over the clamped rectangle of the mirror
  function automatic window_result_t window_min_max(input txn_t t);
    window_result_t res;
    int unsigned    w;
    int unsigned    h;
    int             lo_v;
    int             hi_v;
    int             s;
    w = grid_dim(width_reg, MaxColsDef);
    h = grid_dim(height_reg, MaxRowsDef);
    if (t.col_lo > t.col_hi || t.row_lo > t.row_hi) begin
      res.min_e = EmptyMin;
      res.max_e = EmptyMax;
      res.empty = 1'b1;
      return res;
    end
    lo_v = 32'sh7fffffff;
    hi_v = -32'sh7fffffff - 1;
    for (int unsigned r = clamp_index(t.row_lo, h); r <= clamp_index(t.row_hi, h); r++) begin
      for (int unsigned c = clamp_index(t.col_lo, w); c <= clamp_index(t.col_hi, w); c++) begin
        s = int'(elev_mirror[StoreAddrW'(r * w + c)]);
        if (s < lo_v) lo_v = s;
        if (s > hi_v) hi_v = s;
      end
    end
    res.min_e = lo_v[ElevW-1:0];
    res.max_e = hi_v[ElevW-1:0];
    res.empty = 1'b0;
    return res;
  endfunction

  // random transaction, mostly around a hot spot so queries see recent writes
  function automatic txn_t random_txn(input logic [IdxW-1:0] hot_c, input logic [IdxW-1:0] hot_r);
    txn_t        t;
    int unsigned w;
    int unsigned h;
    int unsigned roll;
    w = grid_dim(width_reg, MaxColsDef);
    h = grid_dim(height_reg, MaxRowsDef);
    t.func   = ($urandom_range(99) < 45) ? FuncWrite : FuncQuery;
    t.sample = ElevW'($urandom);
    roll = $urandom_range(99);
    if (roll < 4) t.sample = 16'sh7fff;
    else if (roll < 8) t.sample = 16'sh8000;
    else if (roll < 10) t.sample = 16'sh0;
    if ($urandom_range(99) < 80) begin
      t.col_lo = hot_c + IdxW'($urandom_range(15));
      t.row_lo = hot_r + IdxW'($urandom_range(15));
      t.col_hi = t.col_lo + IdxW'($urandom_range(9));
      t.row_hi = t.row_lo + IdxW'($urandom_range(9));
    end else if (w * h <= 1024) begin
      t.col_lo = IdxW'($urandom);
      t.col_hi = IdxW'($urandom);
      t.row_lo = IdxW'($urandom);
      t.row_hi = IdxW'($urandom);
    end else begin
      t.col_lo = IdxW'($urandom);
      t.row_lo = IdxW'($urandom);
      t.col_hi = t.col_lo + IdxW'($urandom_range(20));
      t.row_hi = t.row_lo + IdxW'($urandom_range(20));
    end
    // broken windows on purpose
    roll = $urandom_range(99);
    if (roll < 4) t.col_hi = t.col_lo - IdxW'($urandom_range(1, 3));
    else if (roll < 8) t.row_hi = t.row_lo - IdxW'($urandom_range(1, 3));
    if (t.func == FuncWrite) begin
      t.col_hi = IdxW'($urandom);
      t.row_hi = IdxW'($urandom);
    end
    return t;
  endfunction

  // present one transaction, hold it until taken, then update the mirror
  task automatic send_txn(input txn_t t, input bit known, input window_result_t known_res);
    window_result_t res;
    int unsigned    w;
    int unsigned    h;
    if (!quiet_stretch && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start          <= 1'b1;
    func_i         <= t.func;
    col_lo_i       <= t.col_lo;
    col_hi_i       <= t.col_hi;
    row_lo_i       <= t.row_lo;
    row_hi_i       <= t.row_hi;
    sample_value_i <= t.sample;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    if (t.func == FuncWrite) begin
      // samples are already SAMPLE_BITS wide, saturation leaves them unchanged
      w = grid_dim(width_reg, MaxColsDef);
      h = grid_dim(height_reg, MaxRowsDef);
      elev_mirror[StoreAddrW'(clamp_index(t.row_lo, h) * w + clamp_index(t.col_lo, w))] =
        t.sample;
      n_writes++;
    end else begin
      res = known ? known_res : window_min_max(t);
      pending_windows.push_back(res);
      n_queries++;
      if (res.empty) n_empty++;
    end
  endtask

  // stop sending and let every pending result and write finish
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] sel, input logic [DimW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (sel == CfgGridWidth) width_reg = value;
    else height_reg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && done_o) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected result min %0d max %0d empty %0b", $time,
                 min_elevation_o, max_elevation_o, empty_window_o);
        n_mismatch++;
      end else begin
        want = pending_windows.pop_front();
        n_checked++;
        if (min_elevation_o !== want.min_e) begin
          $display("%0t: min_elevation expected %0d got %0d", $time, want.min_e,
                   min_elevation_o);
          n_mismatch++;
        end
        if (max_elevation_o !== want.max_e) begin
          $display("%0t: max_elevation expected %0d got %0d", $time, want.max_e,
                   max_elevation_o);
          n_mismatch++;
        end
        if (empty_window_o !== want.empty) begin
          $display("%0t: empty_window expected %0b got %0b", $time, want.empty,
                   empty_window_o);
          n_mismatch++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timed out after %0d cycles with %0d results pending", cycle_count,
               pending_windows.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    txn_t            t;
    window_result_t  fixed_res;
    logic [DimW-1:0] set_w;
    logic [DimW-1:0] set_h;
    logic [IdxW-1:0] hot_c;
    logic [IdxW-1:0] hot_r;
    foreach (elev_mirror[i]) elev_mirror[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        wait_idle();
        write_reg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
        if (dir_rows[i].cfg_sel == CfgGridHeight) n_settings++;
      end else begin
        t.func      = dir_rows[i].func;
        t.col_lo    = dir_rows[i].col_lo;
        t.col_hi    = dir_rows[i].col_hi;
        t.row_lo    = dir_rows[i].row_lo;
        t.row_hi    = dir_rows[i].row_hi;
        t.sample    = dir_rows[i].sample;
        fixed_res.min_e = dir_rows[i].fx_min;
        fixed_res.max_e = dir_rows[i].fx_max;
        fixed_res.empty = dir_rows[i].fx_empty;
        send_txn(t, dir_rows[i].kind == RowTxnFixed, fixed_res);
      end
    end

    // random part, one grid setting per phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin set_w = 9'd256; set_h = 9'd256; end
        1:       begin set_w = 9'd0;   set_h = 9'd0;   end
        2:       begin set_w = 9'd511; set_h = 9'd511; end
        3:       begin set_w = 9'd2;   set_h = 9'd256; end
        4:       begin set_w = 9'd256; set_h = 9'd2;   end
        5:       begin set_w = 9'd17;  set_h = 9'd5;   end
        default: begin
          set_w = DimW'(($urandom_range(1) != 0) ? $urandom_range(0, 20)
                                                 : $urandom_range(0, 511));
          set_h = DimW'(($urandom_range(1) != 0) ? $urandom_range(0, 20)
                                                 : $urandom_range(0, 511));
        end
      endcase
      wait_idle();
      write_reg(CfgGridWidth, set_w);
      write_reg(CfgGridHeight, set_h);
      n_settings++;
      // one phase runs without the random sender gaps, only the rare idle waits
      quiet_stretch = (ph == 3);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 32 == 0) begin
          hot_c = IdxW'(($urandom_range(1) != 0)
                        ? $urandom_range(0, grid_dim(width_reg, MaxColsDef) - 1) : $urandom);
          hot_r = IdxW'(($urandom_range(1) != 0)
                        ? $urandom_range(0, grid_dim(height_reg, MaxRowsDef) - 1) : $urandom);
        end
        if ($urandom_range(199) == 0) wait_idle();
        send_txn(random_txn(hot_c, hot_r), 1'b0, fixed_res);
      end
    end

    // drain and finish
    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("covered %0d writes and %0d queries (%0d empty windows) over %0d grid sizes",
             n_writes, n_queries, n_empty, n_settings);
    $display("%0d results checked, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gwmm_pkg.sv
rtl/core/gwmm_ram.sv
rtl/core/gwmm_minmax.sv
rtl/core/gwmm_seq.sv
rtl/core/grid_window_min_max.sv
sim/grid_window_min_max_tb.sv
